// ===== design/bfm_pkg.sv =====
// Shared types and constants for the tape machine step engine.
`default_nettype none

package bfm_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_APPEND  = 2'd1,
      OP_RESTART = 2'd2,
      OP_STEP    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMIT      = 3'd1,
      ST_WAIT      = 3'd2,
      ST_DONE      = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_UNMATCHED = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   // Instruction characters.
   localparam logic [7:0] CH_RIGHT = 8'h3E;
   localparam logic [7:0] CH_LEFT  = 8'h3C;
   localparam logic [7:0] CH_INC   = 8'h2B;
   localparam logic [7:0] CH_DEC   = 8'h2D;
   localparam logic [7:0] CH_OUT   = 8'h2E;
   localparam logic [7:0] CH_IN    = 8'h2C;
   localparam logic [7:0] CH_OPEN  = 8'h5B;
   localparam logic [7:0] CH_CLOSE = 8'h5D;

   localparam int PC_OUT_W = 13;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;    // capture the request fields
      logic sweep;     // write zero to the tape at the sweep counter
      logic exec;      // apply the captured request to the machine state
      logic load_rsp;  // move the pending result into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;  // sweep counter is on the last tape cell
   } stat_type;

endpackage

`default_nettype wire

// ===== design/bfm_datapath.sv =====
// Datapath: program, tape and loop stack memories, machine registers, result registers.
`default_nettype none

module bfm_datapath
   import bfm_pkg::*;
#(
   parameter int TAPE_CELLS = 32768,
   parameter int PROG_DEPTH = 4096,
   parameter int LOOP_DEPTH = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cmd_type       cmd,
   output stat_type           stat,
   input  wire logic [1:0]    req_op,
   input  wire logic [7:0]    req_char,
   input  wire logic [7:0]    req_byte,
   input  wire logic          req_byte_valid,
   output status_type         rsp_status,
   output logic [7:0]         rsp_byte,
   output logic [PC_OUT_W-1:0] rsp_pc
);

   localparam int HW  = $clog2(TAPE_CELLS);
   localparam int PAW = $clog2(PROG_DEPTH);
   localparam int PCW = PAW + 1;
   localparam int SAW = $clog2(LOOP_DEPTH);
   localparam int LVW = SAW + 1;

   // Memories.
   logic [7:0]     prog_mem  [PROG_DEPTH];
   logic [7:0]     tape_mem  [TAPE_CELLS];
   logic [PAW-1:0] stack_mem [LOOP_DEPTH];

   // Machine state.
   logic [PCW-1:0] pc_ff, pc_in;
   logic [PCW-1:0] plen_ff, plen_in;
   logic [HW-1:0]  head_ff, head_in;
   logic [LVW-1:0] level_ff, level_in;
   logic [PCW-1:0] skip_ff, skip_in;
   logic           err_ff, err_in;
   logic [HW-1:0]  sweep_ff;

   // Captured request.
   op_type         op_ff;
   logic [7:0]     char_ff;
   logic [7:0]     byte_ff;
   logic           bvalid_ff;

   // Registered memory reads.
   logic [7:0]     prog_rd_ff;
   logic [7:0]     cell_rd_ff;
   logic [PAW-1:0] top_rd_ff;

   // Pending and output results.
   status_type     pend_status_ff, res_status;
   logic [7:0]     pend_byte_ff, res_byte;
   logic [PCW-1:0] pend_pc_ff;
   status_type     rsp_status_ff;
   logic [7:0]     rsp_byte_ff;
   logic [PC_OUT_W-1:0] rsp_pc_ff;

   logic           tape_we;
   logic [HW-1:0]  tape_waddr;
   logic [7:0]     tape_wdata;
   logic           cell_we;
   logic [7:0]     cell_wdata;
   logic           push_we;
   logic           prog_we;
   logic [SAW-1:0] top_addr;
   logic           halted;
   logic [31:0]    pend_pc_wide;

   assign stat.sweep_last = (sweep_ff == HW'(TAPE_CELLS - 1));

   assign top_addr = (level_ff == '0) ? '0 : SAW'(level_ff - LVW'(1));
   assign halted   = err_ff || (pc_ff >= plen_ff) || (pc_ff >= PCW'(PROG_DEPTH));

   // Next state of one request.
   always_comb begin
      pc_in      = pc_ff;
      plen_in    = plen_ff;
      head_in    = head_ff;
      level_in   = level_ff;
      skip_in    = skip_ff;
      err_in     = err_ff;
      cell_we    = 1'b0;
      cell_wdata = cell_rd_ff;
      push_we    = 1'b0;
      prog_we    = 1'b0;
      res_status = ST_OK;
      res_byte   = 8'd0;
      case (op_ff)
         OP_CLEAR: begin
            pc_in    = '0;
            plen_in  = '0;
            head_in  = '0;
            level_in = '0;
            skip_in  = '0;
            err_in   = 1'b0;
         end
         OP_APPEND: begin
            if (plen_ff >= PCW'(PROG_DEPTH)) begin
               res_status = ST_FULL;
            end else begin
               prog_we = 1'b1;
               plen_in = plen_ff + PCW'(1);
            end
         end
         OP_RESTART: begin
            pc_in    = '0;
            head_in  = '0;
            level_in = '0;
            skip_in  = '0;
            err_in   = 1'b0;
         end
         OP_STEP: begin
            if (halted) begin
               res_status = ST_DONE;
            end else if (skip_ff != '0) begin
               // Skipping a loop body: only track bracket nesting.
               if (prog_rd_ff == CH_OPEN) begin
                  skip_in = skip_ff + PCW'(1);
               end else if (prog_rd_ff == CH_CLOSE) begin
                  skip_in = skip_ff - PCW'(1);
               end
               pc_in = pc_ff + PCW'(1);
            end else begin
               pc_in = pc_ff + PCW'(1);
               case (prog_rd_ff)
                  CH_RIGHT: begin
                     head_in = (head_ff == HW'(TAPE_CELLS - 1)) ? '0 : head_ff + HW'(1);
                  end
                  CH_LEFT: begin
                     head_in = (head_ff == '0) ? HW'(TAPE_CELLS - 1) : head_ff - HW'(1);
                  end
                  CH_INC: begin
                     cell_we    = 1'b1;
                     cell_wdata = cell_rd_ff + 8'd1;
                  end
                  CH_DEC: begin
                     cell_we    = 1'b1;
                     cell_wdata = cell_rd_ff - 8'd1;
                  end
                  CH_OUT: begin
                     res_status = ST_EMIT;
                     res_byte   = cell_rd_ff;
                  end
                  CH_IN: begin
                     if (!bvalid_ff) begin
                        res_status = ST_WAIT;
                        pc_in      = pc_ff;
                     end else begin
                        cell_we    = 1'b1;
                        cell_wdata = byte_ff;
                     end
                  end
                  CH_OPEN: begin
                     if (cell_rd_ff == 8'd0) begin
                        skip_in = PCW'(1);
                     end else if (level_ff >= LVW'(LOOP_DEPTH)) begin
                        err_in     = 1'b1;
                        res_status = ST_OVERFLOW;
                        pc_in      = pc_ff;
                     end else begin
                        push_we  = 1'b1;
                        level_in = level_ff + LVW'(1);
                     end
                  end
                  CH_CLOSE: begin
                     if (level_ff == '0) begin
                        err_in     = 1'b1;
                        res_status = ST_UNMATCHED;
                        pc_in      = pc_ff;
                     end else if (cell_rd_ff != 8'd0) begin
                        pc_in = PCW'(top_rd_ff) + PCW'(1);
                     end else begin
                        level_in = level_ff - LVW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // One tape write port shared by the clearing sweep and the step logic.
   always_comb begin
      if (cmd.sweep) begin
         tape_we    = 1'b1;
         tape_waddr = sweep_ff;
         tape_wdata = 8'd0;
      end else begin
         tape_we    = cmd.exec && cell_we;
         tape_waddr = head_ff;
         tape_wdata = cell_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      cell_rd_ff <= tape_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && prog_we) begin
         prog_mem[plen_ff[PAW-1:0]] <= char_ff;
      end
      prog_rd_ff <= prog_mem[pc_ff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && push_we) begin
         stack_mem[level_ff[SAW-1:0]] <= pc_ff[PAW-1:0];
      end
      top_rd_ff <= stack_mem[top_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         plen_ff  <= '0;
         head_ff  <= '0;
         level_ff <= '0;
         skip_ff  <= '0;
         err_ff   <= 1'b0;
         sweep_ff <= '0;
      end else begin
         sweep_ff <= cmd.sweep ? sweep_ff + HW'(1) : '0;
         if (cmd.exec) begin
            pc_ff    <= pc_in;
            plen_ff  <= plen_in;
            head_ff  <= head_in;
            level_ff <= level_in;
            skip_ff  <= skip_in;
            err_ff   <= err_in;
         end
      end
   end

   assign pend_pc_wide = 32'(pend_pc_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= op_type'(req_op);
         char_ff   <= req_char;
         byte_ff   <= req_byte;
         bvalid_ff <= req_byte_valid;
      end
      if (cmd.exec) begin
         pend_status_ff <= res_status;
         pend_byte_ff   <= res_byte;
         pend_pc_ff     <= pc_in;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_byte_ff   <= pend_byte_ff;
         rsp_pc_ff     <= pend_pc_wide[PC_OUT_W-1:0];
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_pc     = rsp_pc_ff;

endmodule

`default_nettype wire

// ===== design/bfm_ctrl.sv =====
// Controller: request and result handshakes and sequencing of each request.
`default_nettype none

module bfm_ctrl
   import bfm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_op,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire stat_type   stat
);

   typedef enum logic [2:0] {
      S_INIT_CLEAR,
      S_IDLE,
      S_CLEAR,
      S_EXEC,
      S_RESULT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == S_RESULT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      cmd.accept   = accept;
      cmd.sweep    = (state_ff == S_INIT_CLEAR) || (state_ff == S_CLEAR);
      cmd.exec     = (state_ff == S_EXEC);
      cmd.load_rsp = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT_CLEAR: begin
               if (stat.sweep_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= (op_type'(req_op) == OP_CLEAR) ? S_CLEAR : S_EXEC;
               end
            end
            S_CLEAR: begin
               if (stat.sweep_last) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/brainfuck_machine_step.sv =====
// Top level of the tape machine step engine: one response per request.
// A request passes through accept, execute and result load; a clear request adds
// a sweep over all TAPE_CELLS cells that zeroes the tape through its single write port.
// A new request is taken only after the previous result has been loaded into the
// output register; the registered reads of the program, tape and loop stack memories
// precede the execute cycle. After reset the same sweep runs before req_tready rises.
`default_nettype none

module brainfuck_machine_step
   import bfm_pkg::*;
#(
   parameter int TAPE_CELLS = 32768,
   parameter int PROG_DEPTH = 4096,
   parameter int LOOP_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] prog_char, [15:8] in_byte
   input  wire logic [2:0]  req_tuser,   // [1:0] op, [2] in_valid
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [20:8] prog_counter, [23:21] zero
   output logic [2:0]       rsp_tuser    // [2:0] status
);

   cmd_type    cmd;
   stat_type   stat;
   status_type rsp_status;
   logic [7:0] rsp_byte;
   logic [PC_OUT_W-1:0] rsp_pc;

   // The controller owns both handshakes and walks each request through
   // accept, an optional tape sweep, execute and result load. The output
   // register lets a finished response wait while the next request is taken.
   bfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser[1:0]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // The datapath holds the program store, the tape, the loop return stack
   // and the machine registers. Reads of all three memories are issued every
   // cycle from the current pc, head and stack level, so their data is ready
   // in the cycle after a request is accepted.
   bfm_datapath #(
      .TAPE_CELLS (TAPE_CELLS),
      .PROG_DEPTH (PROG_DEPTH),
      .LOOP_DEPTH (LOOP_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_tuser[1:0]),
      .req_char       (req_tdata[7:0]),
      .req_byte       (req_tdata[15:8]),
      .req_byte_valid (req_tuser[2]),
      .rsp_status     (rsp_status),
      .rsp_byte       (rsp_byte),
      .rsp_pc         (rsp_pc)
   );

   // Pack the response fields, lowest field first.
   assign rsp_tdata = {3'd0, rsp_pc, rsp_byte};
   assign rsp_tuser = rsp_status;

endmodule

`default_nettype wire
